### rtl/assert_macros.svh
// Assertion macros for the top level RTL file, which checks its own behaviour
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge, ignored while reset is high
`define RCAG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Check a property on every rising edge, reset included
`define RCAG_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define RCAG_ASSERT(label, clk, rst, prop)
`define RCAG_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### rtl/rcag_pkg.sv
// Shared constants, types and helper functions of the reorg copy address generator
`default_nettype none

package rcag_pkg;

   // Output field widths
   localparam int unsigned OUT_BITS            = 24;
   localparam int unsigned LEN_BITS            = 14;
   localparam int unsigned OFFSET_BITS_DEFAULT = 24;
   // Full width of internal offsets, wide enough for the largest tensor walk
   localparam int unsigned SUM_BITS            = 41;

   // Register widths
   localparam int unsigned SCALE_BITS    = 4;
   localparam int unsigned BATCHES_BITS  = 5;
   localparam int unsigned DIM_BITS      = 9;
   localparam int unsigned CHANNELS_BITS = 11;

   // Walk counter widths
   localparam int unsigned BATCH_CNT_BITS  = 4;
   localparam int unsigned ROW_CNT_BITS    = 8;
   localparam int unsigned COL_CNT_BITS    = 8;
   localparam int unsigned SUBROW_CNT_BITS = 3;

   // Configuration port
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 11;

   localparam logic [CSR_INDEX_BITS-1:0] CFG_SCALE          = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CFG_REVERSE        = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CFG_BATCHES        = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CFG_COMPACT_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CFG_COMPACT_WIDTH  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CFG_WIDE_CHANNELS  = 3'd5;

   // Register reset values
   localparam logic [SCALE_BITS-1:0]    SCALE_RESET    = 4'd2;
   localparam logic                     REVERSE_RESET  = 1'b0;
   localparam logic [BATCHES_BITS-1:0]  BATCHES_RESET  = 5'd1;
   localparam logic [DIM_BITS-1:0]      HEIGHT_RESET   = 9'd13;
   localparam logic [DIM_BITS-1:0]      WIDTH_RESET    = 9'd13;
   localparam logic [CHANNELS_BITS-1:0] CHANNELS_RESET = 11'd64;

   // Saturation bounds
   localparam logic [SCALE_BITS-1:0]    SCALE_MAX    = 4'd8;
   localparam logic [BATCHES_BITS-1:0]  BATCHES_MAX  = 5'd16;
   localparam logic [DIM_BITS-1:0]      DIM_MAX      = 9'd256;
   localparam logic [CHANNELS_BITS-1:0] CHANNELS_MAX = 11'd1024;

   // Configuration as used by the datapath, already saturated
   typedef struct packed {
      logic [SCALE_BITS-1:0]    scale;
      logic                     reverse;
      logic [BATCHES_BITS-1:0]  batches;
      logic [DIM_BITS-1:0]      height;
      logic [DIM_BITS-1:0]      width;
      logic [CHANNELS_BITS-1:0] channels;
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic div_step;
      logic mul1;
      logic mul2;
      logic mul3;
      logic mul4;
      logic load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic div_done;
   } status_type;

   function automatic logic [SCALE_BITS-1:0] sat_scale(input logic [SCALE_BITS-1:0] v);
      logic [SCALE_BITS-1:0] r;
      r = v;
      if (v == '0) r = SCALE_BITS'(1);
      else if (v > SCALE_MAX) r = SCALE_MAX;
      return r;
   endfunction

   function automatic logic [BATCHES_BITS-1:0] sat_batches(
      input logic [BATCHES_BITS-1:0] v);
      logic [BATCHES_BITS-1:0] r;
      r = v;
      if (v == '0) r = BATCHES_BITS'(1);
      else if (v > BATCHES_MAX) r = BATCHES_MAX;
      return r;
   endfunction

   function automatic logic [DIM_BITS-1:0] sat_dim(input logic [DIM_BITS-1:0] v);
      logic [DIM_BITS-1:0] r;
      r = v;
      if (v == '0) r = DIM_BITS'(1);
      else if (v > DIM_MAX) r = DIM_MAX;
      return r;
   endfunction

   function automatic logic [CHANNELS_BITS-1:0] sat_channels(
      input logic [CHANNELS_BITS-1:0] v);
      logic [CHANNELS_BITS-1:0] r;
      r = v;
      if (v == '0) r = CHANNELS_BITS'(1);
      else if (v > CHANNELS_MAX) r = CHANNELS_MAX;
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/rcag_ctrl.sv
// Sequencing state machine and result valid of the reorg copy address generator
`default_nettype none

module rcag_ctrl import rcag_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_MUL1 = 3'd2;
   localparam logic [2:0] ST_MUL2 = 3'd3;
   localparam logic [2:0] ST_MUL3 = 3'd4;
   localparam logic [2:0] ST_MUL4 = 3'd5;
   localparam logic [2:0] ST_LOAD = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   // Output register may take a new result when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Step through divide, multiply and load
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.mul3 = 1'b1;
            state_in = ST_MUL4;
         end
         ST_MUL4: begin
            cmd.mul4 = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Set on load, drop once the response is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/rcag_dp.sv
// Walk counters, row divider, offset arithmetic and response register
`default_nettype none

module rcag_dp import rcag_pkg::*; #(
   parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic                req_restart,
   output logic [OUT_BITS-1:0] rsp_compact_offset,
   output logic [OUT_BITS-1:0] rsp_wide_offset,
   output logic [LEN_BITS-1:0] rsp_copy_length,
   output logic                rsp_to_wide,
   output logic                rsp_last,
   output logic                rsp_out_of_range
);

   localparam int unsigned DIV_CNT_BITS = $clog2(ROW_CNT_BITS);

   // Walk state
   logic [BATCH_CNT_BITS-1:0]  batch_ff;
   logic [ROW_CNT_BITS-1:0]    row_ff;
   logic [COL_CNT_BITS-1:0]    col_ff;
   logic [SUBROW_CNT_BITS-1:0] subrow_ff;
   logic [SUM_BITS-1:0]        pointer_ff;

   logic [BATCH_CNT_BITS-1:0]  batch_in;
   logic [ROW_CNT_BITS-1:0]    row_in;
   logic [COL_CNT_BITS-1:0]    col_in;
   logic [SUBROW_CNT_BITS-1:0] subrow_in;
   logic [SUM_BITS-1:0]        pointer_in;

   logic [BATCH_CNT_BITS-1:0]  cur_batch;
   logic [ROW_CNT_BITS-1:0]    cur_row;
   logic [COL_CNT_BITS-1:0]    cur_col;
   logic [SUBROW_CNT_BITS-1:0] cur_subrow;
   logic [SUM_BITS-1:0]        cur_pointer;

   logic [SCALE_BITS-1:0]      subrow_inc;
   logic [DIM_BITS-1:0]        col_inc;
   logic [DIM_BITS-1:0]        row_inc;
   logic [BATCHES_BITS-1:0]    batch_inc;
   logic                       subrow_wrap;
   logic                       col_wrap;
   logic                       row_wrap;
   logic                       batch_wrap;
   logic                       is_last;

   logic [LEN_BITS:0]          len_full;
   logic [LEN_BITS-1:0]        len;

   // Snapshot of the request being worked on
   logic [BATCH_CNT_BITS-1:0]  w_batch_ff;
   logic [COL_CNT_BITS-1:0]    w_col_ff;
   logic [SUBROW_CNT_BITS-1:0] w_subrow_ff;
   logic [SUM_BITS-1:0]        w_pointer_ff;
   logic                       w_last_ff;

   // Restoring divider: row by scale
   logic [DIV_CNT_BITS-1:0]    div_cnt_ff;
   logic [ROW_CNT_BITS-1:0]    div_q_ff;
   logic [SCALE_BITS-2:0]      div_rem_ff;
   logic [SCALE_BITS-1:0]      div_trial;
   logic                       div_bit;

   // Arithmetic stages
   logic [10:0]                qs_ff;
   logic [5:0]                 is_ff;
   logic [11:0]                wide_w_ff;
   logic [11:0]                wide_h_ff;
   logic [10:0]                cols_ff;
   logic [13:0]                qss_ff;
   logic [22:0]                row_stride_ff;
   logic [21:0]                colsc_ff;
   logic [14:0]                wide_row_ff;
   logic [34:0]                batch_stride_ff;
   logic [38:0]                boff_ff;
   logic [37:0]                roff_ff;
   logic [SUM_BITS-1:0]        wide_sum;

   // Response register
   logic [OUT_BITS-1:0]        rsp_compact_ff;
   logic [OUT_BITS-1:0]        rsp_wide_ff;
   logic [LEN_BITS-1:0]        rsp_len_ff;
   logic                       rsp_to_wide_ff;
   logic                       rsp_last_ff;
   logic                       rsp_range_ff;

   // Chunk length
   assign len_full = (LEN_BITS + 1)'(cfg.channels) * (LEN_BITS + 1)'(cfg.scale);
   assign len      = len_full[LEN_BITS-1:0];

   // Restart clears the walk before this request is served
   assign cur_batch   = req_restart ? '0 : batch_ff;
   assign cur_row     = req_restart ? '0 : row_ff;
   assign cur_col     = req_restart ? '0 : col_ff;
   assign cur_subrow  = req_restart ? '0 : subrow_ff;
   assign cur_pointer = req_restart ? '0 : pointer_ff;

   // Carry chain of the walk
   assign subrow_inc  = SCALE_BITS'(cur_subrow) + SCALE_BITS'(1);
   assign col_inc     = DIM_BITS'(cur_col) + DIM_BITS'(1);
   assign row_inc     = DIM_BITS'(cur_row) + DIM_BITS'(1);
   assign batch_inc   = BATCHES_BITS'(cur_batch) + BATCHES_BITS'(1);
   assign subrow_wrap = subrow_inc >= cfg.scale;
   assign col_wrap    = col_inc >= cfg.width;
   assign row_wrap    = row_inc >= cfg.height;
   assign batch_wrap  = batch_inc >= cfg.batches;
   assign is_last     = subrow_wrap && col_wrap && row_wrap && batch_wrap;

   // Advance the walk past the current descriptor
   always_comb begin
      subrow_in  = subrow_inc[SUBROW_CNT_BITS-1:0];
      col_in     = cur_col;
      row_in     = cur_row;
      batch_in   = cur_batch;
      pointer_in = cur_pointer + SUM_BITS'(len);
      if (subrow_wrap) begin
         subrow_in = '0;
         col_in    = col_inc[COL_CNT_BITS-1:0];
         if (col_wrap) begin
            col_in = '0;
            row_in = row_inc[ROW_CNT_BITS-1:0];
            if (row_wrap) begin
               row_in   = '0;
               batch_in = batch_inc[BATCH_CNT_BITS-1:0];
               if (batch_wrap) begin
                  batch_in   = '0;
                  pointer_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff   <= '0;
         row_ff     <= '0;
         col_ff     <= '0;
         subrow_ff  <= '0;
         pointer_ff <= '0;
      end else if (cmd.accept) begin
         batch_ff   <= batch_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         subrow_ff  <= subrow_in;
         pointer_ff <= pointer_in;
      end
   end

   // One quotient bit per step
   assign div_trial = {div_rem_ff, div_q_ff[ROW_CNT_BITS-1]};
   assign div_bit   = div_trial >= cfg.scale;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.accept) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + DIV_CNT_BITS'(1);
      end
   end

   // The count only reaches its top value on the final divider step
   assign status.div_done = (div_cnt_ff == '1);

   // Capture the request and run the arithmetic stages
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         w_batch_ff   <= cur_batch;
         w_col_ff     <= cur_col;
         w_subrow_ff  <= cur_subrow;
         w_pointer_ff <= cur_pointer;
         w_last_ff    <= is_last;
         div_q_ff     <= cur_row;
         div_rem_ff   <= '0;
      end else if (cmd.div_step) begin
         div_q_ff   <= {div_q_ff[ROW_CNT_BITS-2:0], div_bit};
         div_rem_ff <= div_bit ? (SCALE_BITS - 1)'(div_trial - cfg.scale)
                               : div_trial[SCALE_BITS-2:0];
      end
      if (cmd.mul1) begin
         qs_ff     <= 11'(div_q_ff) * 11'(cfg.scale);
         is_ff     <= 6'(w_subrow_ff) * 6'(cfg.scale);
         wide_w_ff <= 12'(cfg.width) * 12'(cfg.scale);
         wide_h_ff <= 12'(cfg.height) * 12'(cfg.scale);
         cols_ff   <= 11'(w_col_ff) * 11'(cfg.scale);
      end
      if (cmd.mul2) begin
         qss_ff        <= 14'(qs_ff) * 14'(cfg.scale);
         row_stride_ff <= 23'(wide_w_ff) * 23'(cfg.channels);
         colsc_ff      <= 22'(cols_ff) * 22'(cfg.channels);
      end
      if (cmd.mul3) begin
         wide_row_ff     <= 15'(div_rem_ff) + 15'(qss_ff) + 15'(is_ff);
         batch_stride_ff <= 35'(wide_h_ff) * 35'(row_stride_ff);
      end
      if (cmd.mul4) begin
         boff_ff <= 39'(w_batch_ff) * 39'(batch_stride_ff);
         roff_ff <= 38'(wide_row_ff) * 38'(row_stride_ff);
      end
   end

   // Final sum of the wide offset
   assign wide_sum = SUM_BITS'(boff_ff) + SUM_BITS'(roff_ff) + SUM_BITS'(colsc_ff);

   // Load the response register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_compact_ff <= w_pointer_ff[OUT_BITS-1:0];
         rsp_wide_ff    <= wide_sum[OUT_BITS-1:0];
         rsp_len_ff     <= len;
         rsp_to_wide_ff <= cfg.reverse;
         rsp_last_ff    <= w_last_ff;
         rsp_range_ff   <= ((w_pointer_ff >> OFFSET_BITS) != '0)
                        || ((wide_sum >> OFFSET_BITS) != '0);
      end
   end

   assign rsp_compact_offset = rsp_compact_ff;
   assign rsp_wide_offset    = rsp_wide_ff;
   assign rsp_copy_length    = rsp_len_ff;
   assign rsp_to_wide        = rsp_to_wide_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_out_of_range   = rsp_range_ff;

endmodule

`default_nettype wire

### rtl/reorg_copy_address_generator.sv
// Top level of the reorg copy address generator: registers, controller and datapath
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  restart
//   rsp_      out        rsp_valid/rsp_stall  compact_offset, wide_offset, copy_length,
//                                             to_wide, last, out_of_range
//   csr_      in         csr_write_enable     csr_index, csr_write_data
//
// A request passes through accept, 8 steps of the restoring divider that splits the
// row by the scale (one quotient bit a cycle), 4 multiply stages and the load.
// req_stall is high from accept until the result is loaded into the output register.
// The load waits while the output register is held by rsp_stall.
// Reset is synchronous and clears the walk and restores the register defaults.
`default_nettype none

`include "assert_macros.svh"

module reorg_copy_address_generator import rcag_pkg::*; #(
   parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_restart,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [OUT_BITS-1:0]       rsp_compact_offset,
   output logic [OUT_BITS-1:0]       rsp_wide_offset,
   output logic [LEN_BITS-1:0]       rsp_copy_length,
   output logic                      rsp_to_wide,
   output logic                      rsp_last,
   output logic                      rsp_out_of_range,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   logic [SCALE_BITS-1:0]    scale_ff;
   logic                     reverse_ff;
   logic [BATCHES_BITS-1:0]  batches_ff;
   logic [DIM_BITS-1:0]      height_ff;
   logic [DIM_BITS-1:0]      width_ff;
   logic [CHANNELS_BITS-1:0] channels_ff;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // Write configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff    <= SCALE_RESET;
         reverse_ff  <= REVERSE_RESET;
         batches_ff  <= BATCHES_RESET;
         height_ff   <= HEIGHT_RESET;
         width_ff    <= WIDTH_RESET;
         channels_ff <= CHANNELS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CFG_SCALE:          scale_ff    <= csr_write_data[SCALE_BITS-1:0];
            CFG_REVERSE:        reverse_ff  <= csr_write_data[0];
            CFG_BATCHES:        batches_ff  <= csr_write_data[BATCHES_BITS-1:0];
            CFG_COMPACT_HEIGHT: height_ff   <= csr_write_data[DIM_BITS-1:0];
            CFG_COMPACT_WIDTH:  width_ff    <= csr_write_data[DIM_BITS-1:0];
            CFG_WIDE_CHANNELS:  channels_ff <= csr_write_data[CHANNELS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Saturate registers into their meaningful ranges
   assign cfg.scale    = sat_scale(scale_ff);
   assign cfg.reverse  = reverse_ff;
   assign cfg.batches  = sat_batches(batches_ff);
   assign cfg.height   = sat_dim(height_ff);
   assign cfg.width    = sat_dim(width_ff);
   assign cfg.channels = sat_channels(channels_ff);

   rcag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rcag_dp #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .cmd                (cmd),
      .status             (status),
      .req_restart        (req_restart),
      .rsp_compact_offset (rsp_compact_offset),
      .rsp_wide_offset    (rsp_wide_offset),
      .rsp_copy_length    (rsp_copy_length),
      .rsp_to_wide        (rsp_to_wide),
      .rsp_last           (rsp_last),
      .rsp_out_of_range   (rsp_out_of_range)
   );

   // An accepted request starts the divider next cycle
   `RCAG_ASSERT(a_accept_starts_div, clock, reset, cmd.accept |=> cmd.div_step)
   // Divider completion hands over to the first multiply stage
   `RCAG_ASSERT(a_div_to_mul, clock, reset, status.div_done |=> cmd.mul1)
   // Never overwrite a response that is still held
   `RCAG_ASSERT(a_load_when_free, clock, reset, cmd.load |-> !(rsp_valid && rsp_stall))
   // After a load the block is ready and a response is on offer
   `RCAG_ASSERT(a_load_then_ready, clock, reset, cmd.load |=> (!req_stall && rsp_valid))

endmodule

`default_nettype wire

### bench/tb_reorg_copy_address_generator.sv
// Self-checking testbench of the reorg copy address generator: directed and random walks
module tb_reorg_copy_address_generator import rcag_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned OFFSET_BITS = OFFSET_BITS_DEFAULT;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned PRINT_LIMIT = 50;

   typedef struct packed {
      logic [OUT_BITS-1:0] compact_offset;
      logic [OUT_BITS-1:0] wide_offset;
      logic [LEN_BITS-1:0] copy_length;
      logic                to_wide;
      logic                last;
      logic                out_of_range;
   } descriptor_type;

   typedef struct packed {
      logic restart;
      logic drain;
   } walk_request_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_restart = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [OUT_BITS-1:0]       rsp_compact_offset;
   logic [OUT_BITS-1:0]       rsp_wide_offset;
   logic [LEN_BITS-1:0]       rsp_copy_length;
   logic                      rsp_to_wide;
   logic                      rsp_last;
   logic                      rsp_out_of_range;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CFG_SCALE;
   logic [CSR_DATA_BITS-1:0]  csr_write_data = '0;

   // Register copies, as written (masked to their widths)
   longint unsigned cfg_scale    = SCALE_RESET;
   longint unsigned cfg_reverse  = REVERSE_RESET;
   longint unsigned cfg_batches  = BATCHES_RESET;
   longint unsigned cfg_height   = HEIGHT_RESET;
   longint unsigned cfg_width    = WIDTH_RESET;
   longint unsigned cfg_channels = CHANNELS_RESET;

   // Walk position of the predictor
   longint unsigned walk_batch   = 0;
   longint unsigned walk_row     = 0;
   longint unsigned walk_column  = 0;
   longint unsigned walk_subrow  = 0;
   longint unsigned compact_ptr  = 0;

   walk_request_type walk_requests[$];
   descriptor_type   pending_descriptors[$];
   descriptor_type   want;
   int unsigned      send_idle_pct = 0;
   int unsigned      recv_idle_pct = 0;
   int unsigned      mismatch_count = 0;
   int unsigned      descriptor_count = 0;
   int unsigned      cycle_count = 0;

   reorg_copy_address_generator #(.OFFSET_BITS(OFFSET_BITS)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_compact_offset (rsp_compact_offset),
      .rsp_wide_offset    (rsp_wide_offset),
      .rsp_copy_length    (rsp_copy_length),
      .rsp_to_wide        (rsp_to_wide),
      .rsp_last           (rsp_last),
      .rsp_out_of_range   (rsp_out_of_range),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #2 clock = ~clock;

   function automatic longint unsigned saturate(input longint unsigned v,
                                                input longint unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Produce the descriptor of one request and step the walk past it
   function automatic descriptor_type advance_walk(input logic restart);
      longint unsigned s, nb, hh, ww, cc, len, row_stride, batch_stride;
      longint unsigned wide_row, wide_off, limit;
      descriptor_type d;
      s  = saturate(cfg_scale, SCALE_MAX);
      nb = saturate(cfg_batches, BATCHES_MAX);
      hh = saturate(cfg_height, DIM_MAX);
      ww = saturate(cfg_width, DIM_MAX);
      cc = saturate(cfg_channels, CHANNELS_MAX);
      len = cc * s;
      row_stride = ww * s * cc;
      batch_stride = hh * s * row_stride;
      limit = (64'd1 << OFFSET_BITS) - 1;
      if (restart) begin
         walk_batch  = 0;
         walk_row    = 0;
         walk_column = 0;
         walk_subrow = 0;
         compact_ptr = 0;
      end
      wide_row = walk_row % s + (walk_row / s) * s * s + walk_subrow * s;
      wide_off = walk_batch * batch_stride + wide_row * row_stride + walk_column * s * cc;
      d.compact_offset = compact_ptr[OUT_BITS-1:0];
      d.wide_offset    = wide_off[OUT_BITS-1:0];
      d.copy_length    = len[LEN_BITS-1:0];
      d.to_wide        = cfg_reverse[0];
      d.last           = walk_subrow + 1 >= s && walk_column + 1 >= ww
                         && walk_row + 1 >= hh && walk_batch + 1 >= nb;
      d.out_of_range   = compact_ptr > limit || wide_off > limit;
      // Carry through sub-row, column, row and batch
      compact_ptr += len;
      walk_subrow++;
      if (walk_subrow >= s) begin
         walk_subrow = 0;
         walk_column++;
         if (walk_column >= ww) begin
            walk_column = 0;
            walk_row++;
            if (walk_row >= hh) begin
               walk_row = 0;
               walk_batch++;
               if (walk_batch >= nb) begin
                  walk_batch = 0;
                  compact_ptr = 0;
               end
            end
         end
      end
      return d;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, what);
   endtask

   task automatic queue_request(input logic restart, input logic drain);
      walk_requests.push_back('{restart: restart, drain: drain});
   endtask

   // Hold until every request is sent and every descriptor has come back
   task automatic wait_idle();
      do @(negedge clock);
      while (walk_requests.size() != 0 || pending_descriptors.size() != 0 || req_valid);
   endtask

   // Write one register, with random bits above its width
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input int unsigned value);
      logic [CSR_DATA_BITS-1:0] data;
      data = CSR_DATA_BITS'($urandom);
      case (index)
         CFG_SCALE: begin
            data[SCALE_BITS-1:0] = SCALE_BITS'(value);
            cfg_scale = data[SCALE_BITS-1:0];
         end
         CFG_REVERSE: begin
            data[0] = value[0];
            cfg_reverse = data[0];
         end
         CFG_BATCHES: begin
            data[BATCHES_BITS-1:0] = BATCHES_BITS'(value);
            cfg_batches = data[BATCHES_BITS-1:0];
         end
         CFG_COMPACT_HEIGHT: begin
            data[DIM_BITS-1:0] = DIM_BITS'(value);
            cfg_height = data[DIM_BITS-1:0];
         end
         CFG_COMPACT_WIDTH: begin
            data[DIM_BITS-1:0] = DIM_BITS'(value);
            cfg_width = data[DIM_BITS-1:0];
         end
         default: begin
            data = CSR_DATA_BITS'(value);
            cfg_channels = data[CHANNELS_BITS-1:0];
         end
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
   endtask

   task automatic program_registers(input int unsigned scale, input int unsigned reverse,
                                    input int unsigned batches, input int unsigned height,
                                    input int unsigned width, input int unsigned channels);
      wait_idle();
      write_register(CFG_SCALE, scale);
      write_register(CFG_REVERSE, reverse);
      write_register(CFG_BATCHES, batches);
      write_register(CFG_COMPACT_HEIGHT, height);
      write_register(CFG_COMPACT_WIDTH, width);
      write_register(CFG_WIDE_CHANNELS, channels);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Request driver: predict on acceptance, then present the next request or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_descriptors.push_back(advance_walk(req_restart));
            void'(walk_requests.pop_front());
         end
         if (!req_valid || !req_stall) begin
            if (walk_requests.size() != 0 && $urandom_range(99) >= send_idle_pct
                && !(walk_requests[0].drain && pending_descriptors.size() != 0)) begin
               req_valid   <= 1'b1;
               req_restart <= walk_requests[0].restart;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Descriptor monitor: stall at random and compare against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= $urandom_range(99) < recv_idle_pct;
         if (rsp_valid && !rsp_stall) begin
            descriptor_count++;
            if (pending_descriptors.size() == 0) begin
               report_mismatch($sformatf("descriptor %0d arrived with none predicted",
                                         descriptor_count));
            end else begin
               want = pending_descriptors.pop_front();
               if (rsp_compact_offset !== want.compact_offset)
                  report_mismatch($sformatf("descriptor %0d compact_offset %0h, predicted %0h",
                     descriptor_count, rsp_compact_offset, want.compact_offset));
               if (rsp_wide_offset !== want.wide_offset)
                  report_mismatch($sformatf("descriptor %0d wide_offset %0h, predicted %0h",
                     descriptor_count, rsp_wide_offset, want.wide_offset));
               if (rsp_copy_length !== want.copy_length)
                  report_mismatch($sformatf("descriptor %0d copy_length %0d, predicted %0d",
                     descriptor_count, rsp_copy_length, want.copy_length));
               if (rsp_to_wide !== want.to_wide)
                  report_mismatch($sformatf("descriptor %0d to_wide %b, predicted %b",
                     descriptor_count, rsp_to_wide, want.to_wide));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("descriptor %0d last %b, predicted %b",
                     descriptor_count, rsp_last, want.last));
               if (rsp_out_of_range !== want.out_of_range)
                  report_mismatch($sformatf("descriptor %0d out_of_range %b, predicted %b",
                     descriptor_count, rsp_out_of_range, want.out_of_range));
            end
         end
      end
   end

   // Abandon a run that hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int unsigned send_pcts[3];
      int unsigned recv_pcts[3];
      send_pcts = '{13, 82, 0};
      recv_pcts = '{82, 13, 0};
      send_idle_pct = send_pcts[0];
      recv_idle_pct = recv_pcts[0];
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: advance from the reset position, then restart
      queue_request(1'b0, 1'b0);
      queue_request(1'b0, 1'b0);
      queue_request(1'b1, 1'b0);
      queue_request(1'b0, 1'b0);
      // Largest tensor: full-length chunks, offsets past the address width
      program_registers(8, 1, 16, 256, 256, 1024);
      queue_request(1'b1, 1'b0);
      repeat (9) queue_request(1'b0, 1'b0);
      // Shrink the scale mid-walk, leaving the sub-row beyond its new bound
      program_registers(2, 1, 16, 256, 256, 1024);
      repeat (2) queue_request(1'b0, 1'b0);
      // Register values above their ranges saturate to the maxima
      program_registers(15, 0, 31, 511, 300, 2047);
      queue_request(1'b1, 1'b0);
      repeat (2) queue_request(1'b0, 1'b0);
      // Zero register values read as one, so every chunk is the last
      program_registers(0, 1, 0, 0, 0, 0);
      queue_request(1'b0, 1'b0);
      queue_request(1'b1, 1'b1);
      repeat (2) queue_request(1'b0, 1'b0);
      // Height not a multiple of the scale
      program_registers(3, 0, 2, 4, 2, 5);
      queue_request(1'b1, 1'b0);
      repeat (5) queue_request(1'b0, 1'b0);

      // Random walks, mostly on small tensors so that they wrap often
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = send_pcts[phase];
         recv_idle_pct = recv_pcts[phase];
         for (int blk = 0; blk < 6; blk++) begin
            if ($urandom_range(7) == 0)
               program_registers($urandom_range(15), $urandom_range(1), $urandom_range(31),
                                 $urandom_range(511), $urandom_range(511),
                                 $urandom_range(2047));
            else
               program_registers($urandom_range(1, 3), $urandom_range(1),
                                 $urandom_range(1, 2), $urandom_range(1, 4),
                                 $urandom_range(1, 4), $urandom_range(1, 1024));
            repeat ($urandom_range(50, 70))
               queue_request($urandom_range(99) < 3, $urandom_range(99) == 0);
         end
      end

      wait_idle();
      repeat (30) @(posedge clock);
      if (pending_descriptors.size() != 0)
         report_mismatch($sformatf("%0d descriptors never arrived", pending_descriptors.size()));
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
